### rtl/core/ihdq_pkg.sv
// package for the interval heap double-ended priority queue
// holds beat structs, opcodes, status codes and size constants; no dependencies
package ihdq_pkg;

   localparam int Capacity  = 1024;
   localparam int AddrWidth = $clog2(Capacity);
   localparam int CountWidth = AddrWidth + 1;
   localparam int NodeWidth = AddrWidth - 1;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_REM_MAX = 2'd1,
      OP_REM_MIN = 2'd2,
      OP_CLEAR   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] key_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0]    removed_key;
      logic                  removed_valid;
      logic signed [31:0]    min_key;
      logic signed [31:0]    max_key;
      logic [10:0]           entry_count;
      logic [1:0]            status;
   } rsp_type;

   // memory port request from the sequencer
   typedef struct packed {
      logic                 rd_en;
      logic [AddrWidth-1:0] rd_addr;
      logic                 wr_en;
      logic [AddrWidth-1:0] wr_addr;
      logic signed [31:0]   wr_data;
   } mem_req_type;

endpackage

### rtl/core/ihdq_ram.sv
// single-port-write, single-port-read key store with registered read data
// depends on ihdq_pkg for widths and the port struct
module ihdq_ram
   import ihdq_pkg::*;
(
   input  logic               clock,
   input  mem_req_type        mem_req,
   output logic signed [31:0] rd_data
);

   logic signed [31:0] mem_array [Capacity];
   logic signed [31:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_array[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_array[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/ihdq_seq.sv
// sequencer: runs insert climbs and removal sinks as read/compare/write steps
// depends on ihdq_pkg; drives the key store through an mem_req_type struct
module ihdq_seq
   import ihdq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  req_type            req,
   output logic               busy,
   output mem_req_type        mem_req,
   input  logic signed [31:0] rd_data,
   output logic               rsp_strobe,
   output rsp_type            rsp
);

   // one read per cycle; value arrives in the next state
   // the moving key stays in a register and its slot (the hole) is written last,
   // so no slot is read in the cycle it is written
   typedef enum logic [13:0] {
      S_IDLE      = 14'b00000000000001,
      S_PAIR      = 14'b00000000000010,  // odd insert: low end of own node arrives
      S_CLIMB_RD  = 14'b00000000000100,  // climb: read parent end, or finish at root
      S_CLIMB_CMP = 14'b00000000001000,  // climb: compare with parent end
      S_REM_KEY   = 14'b00000000010000,  // removal: removed key arrives, read last
      S_REM_LAST  = 14'b00000000100000,  // removal: last key arrives
      S_SNK_P     = 14'b00000001000000,  // sink: read partner end of node
      S_SNK_PC    = 14'b00000010000000,  // sink: fix node order, read child 1
      S_SNK_C1    = 14'b00000100000000,  // sink: child 1 arrives, read child 2
      S_SNK_C2    = 14'b00001000000000,  // sink: pick child, move hole or finish
      S_SNK_END   = 14'b00010000000000,  // sink: write moving key into hole
      S_FIN0      = 14'b00100000000000,  // read slot 0
      S_FIN1      = 14'b01000000000000,  // capture slot 0, read slot 1
      S_FIN2      = 14'b10000000000000   // capture slot 1, raise strobe
   } state_type;

   state_type                state_ff, state_in;
   logic [CountWidth-1:0]    count_ff, count_in;
   logic signed [31:0]       cur_ff, cur_in;         // moving key
   logic [AddrWidth-1:0]     hole_ff, hole_in;       // slot the moving key belongs to
   logic                     dir_ff, dir_in;         // 1 on high ends, 0 on low ends
   logic                     try_high_ff, try_high_in;
   logic signed [31:0]       best_ff, best_in;       // first child candidate
   logic [AddrWidth-1:0]     bslot_ff, bslot_in;
   logic                     c2v_ff, c2v_in;         // second child present
   rsp_type                  rsp_ff, rsp_in;
   logic                     strobe_ff, strobe_in;

   // slot arithmetic around the node that holds the hole
   logic [NodeWidth-1:0]     node;
   logic [NodeWidth-1:0]     node_m1;
   logic [AddrWidth-1:0]     parent_slot;
   logic [CountWidth:0]      n_ext;
   logic [CountWidth:0]      pair_slot;
   logic [CountWidth:0]      c1_lo, c1_hi, c2_lo, c2_hi;
   logic [CountWidth:0]      m1_slot, m2_slot;

   // a is further out than b: above it on high ends, below it on low ends
   function automatic logic beyond(input logic signed [31:0] a,
                                   input logic signed [31:0] b,
                                   input logic hi);
      return hi ? (a > b) : (a < b);
   endfunction

   assign node        = hole_ff[AddrWidth-1:1];
   assign node_m1     = node - 1'b1;
   assign parent_slot = {1'b0, node_m1[NodeWidth-1:1], dir_ff};
   assign n_ext       = {1'b0, count_ff};
   assign pair_slot   = {2'b00, node, 1'b1};                        // 2i+1
   assign c1_lo       = {1'b0, node, 2'b10};                        // 4i+2
   assign c1_hi       = {1'b0, node, 2'b11};                        // 4i+3
   assign c2_lo       = {1'b0, node, 2'b00} + (CountWidth+1)'(4);   // 4i+4
   assign c2_hi       = c2_lo + 1'b1;
   assign m1_slot     = (dir_ff && c1_hi < n_ext) ? c1_hi : c1_lo;
   assign m2_slot     = (dir_ff && c2_hi < n_ext) ? c2_hi : c2_lo;

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp = rsp_ff;

   // next state and memory control
   always_comb begin
      logic                 take_max;
      logic                 swap_pair;
      logic                 use2;
      logic signed [31:0]   sel_key;
      logic [AddrWidth-1:0] sel_slot;
      state_in    = state_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      hole_in     = hole_ff;
      dir_in      = dir_ff;
      try_high_in = try_high_ff;
      best_in     = best_ff;
      bslot_in    = bslot_ff;
      c2v_in      = c2v_ff;
      rsp_in      = rsp_ff;
      strobe_in   = 1'b0;
      mem_req     = '0;
      take_max    = (req.opcode == OP_REM_MAX) && (count_ff != CountWidth'(1));
      swap_pair   = beyond(rd_data, cur_ff, dir_ff);
      use2        = c2v_ff && beyond(rd_data, best_ff, dir_ff);
      sel_key     = use2 ? rd_data : best_ff;
      sel_slot    = use2 ? AddrWidth'(m2_slot) : bslot_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in = '0;
               case (req.opcode)
                  OP_INSERT: begin
                     if (count_ff >= CountWidth'(Capacity)) begin
                        rsp_in.status = ST_FULL;
                        state_in = S_FIN0;
                     end else begin
                        count_in = count_ff + 1'b1;
                        cur_in   = req.key_in;
                        hole_in  = count_ff[AddrWidth-1:0];
                        if (count_ff == '0) begin
                           mem_req.wr_en   = 1'b1;
                           mem_req.wr_addr = '0;
                           mem_req.wr_data = req.key_in;
                           state_in = S_FIN0;
                        end else if (count_ff[0]) begin
                           mem_req.rd_en   = 1'b1;
                           mem_req.rd_addr = count_ff[AddrWidth-1:0] - 1'b1;
                           state_in = S_PAIR;
                        end else begin
                           dir_in      = 1'b0;
                           try_high_in = 1'b1;
                           state_in    = S_CLIMB_RD;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = S_FIN0;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                        state_in = S_FIN0;
                     end else begin
                        dir_in   = take_max;
                        hole_in  = {{(AddrWidth-1){1'b0}}, take_max};
                        count_in = count_ff - 1'b1;
                        rsp_in.removed_valid = 1'b1;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = {{(AddrWidth-1){1'b0}}, take_max};
                        state_in = S_REM_KEY;
                     end
                  end
               endcase
            end
         end

         // odd insert: order against the low end of the same node
         S_PAIR: begin
            if (beyond(cur_ff, rd_data, 1'b0)) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = hole_ff;
               mem_req.wr_data = rd_data;
               hole_in = hole_ff - 1'b1;
               dir_in  = 1'b0;
            end else begin
               dir_in  = 1'b1;
            end
            try_high_in = 1'b0;
            state_in = S_CLIMB_RD;
         end

         // climb: root reached, or fetch the parent end
         S_CLIMB_RD: begin
            if (node == '0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = hole_ff;
               mem_req.wr_data = cur_ff;
               state_in = S_FIN0;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = parent_slot;
               state_in = S_CLIMB_CMP;
            end
         end

         // climb: pull parent end down into the hole, or settle
         S_CLIMB_CMP: begin
            if (beyond(cur_ff, rd_data, dir_ff)) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = hole_ff;
               mem_req.wr_data = rd_data;
               hole_in     = parent_slot;
               try_high_in = 1'b0;
               state_in    = S_CLIMB_RD;
            end else if (try_high_ff) begin
               // even insert not below parent low end: try the high end
               try_high_in = 1'b0;
               dir_in      = 1'b1;
               state_in    = S_CLIMB_RD;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = hole_ff;
               mem_req.wr_data = cur_ff;
               state_in = S_FIN0;
            end
         end

         // removal: capture removed key, read last slot
         S_REM_KEY: begin
            rsp_in.removed_key = rd_data;
            if (count_ff == '0) begin
               state_in = S_FIN0;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = count_ff[AddrWidth-1:0];
               state_in = S_REM_LAST;
            end
         end

         S_REM_LAST: begin
            cur_in   = rd_data;
            state_in = S_SNK_P;
         end

         // sink: partner end of the node, if present
         S_SNK_P: begin
            if (pair_slot < n_ext) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = {node, ~dir_ff};
               state_in = S_SNK_PC;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = hole_ff;
               mem_req.wr_data = cur_ff;
               state_in = S_FIN0;
            end
         end

         // sink: keep low <= high inside the node, then fetch first child
         S_SNK_PC: begin
            if (swap_pair) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = {node, ~dir_ff};
               mem_req.wr_data = cur_ff;
               cur_in = rd_data;
            end
            if (c1_lo >= n_ext) begin
               if (swap_pair) begin
                  state_in = S_SNK_END;
               end else begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = hole_ff;
                  mem_req.wr_data = cur_ff;
                  state_in = S_FIN0;
               end
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = AddrWidth'(m1_slot);
               state_in = S_SNK_C1;
            end
         end

         S_SNK_C1: begin
            best_in  = rd_data;
            bslot_in = AddrWidth'(m1_slot);
            c2v_in   = (c2_lo < n_ext);
            if (c2_lo < n_ext) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = AddrWidth'(m2_slot);
            end
            state_in = S_SNK_C2;
         end

         // sink: move the chosen child end up into the hole, or settle
         S_SNK_C2: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = hole_ff;
            if (beyond(sel_key, cur_ff, dir_ff)) begin
               mem_req.wr_data = sel_key;
               hole_in  = sel_slot;
               state_in = S_SNK_P;
            end else begin
               mem_req.wr_data = cur_ff;
               state_in = S_FIN0;
            end
         end

         S_SNK_END: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = hole_ff;
            mem_req.wr_data = cur_ff;
            state_in = S_FIN0;
         end

         // result collection
         S_FIN0: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = '0;
            state_in = S_FIN1;
         end
         S_FIN1: begin
            rsp_in.min_key  = (count_ff == '0) ? '0 : rd_data;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = (count_ff > CountWidth'(1)) ? AddrWidth'(1) : '0;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            rsp_in.max_key     = (count_ff == '0) ? '0 : rd_data;
            rsp_in.entry_count = 11'(count_ff);
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      hole_ff     <= hole_in;
      dir_ff      <= dir_in;
      try_high_ff <= try_high_in;
      best_ff     <= best_in;
      bslot_ff    <= bslot_in;
      c2v_ff      <= c2v_in;
      rsp_ff      <= rsp_in;
   end

`ifndef SYNTHESIS
   // count never exceeds capacity
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(Capacity)) else $error("count overflow");
   // state register stays one-hot
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   // strobe only on return to idle
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> state_ff == S_IDLE) else $error("strobe outside idle");
   // an accepted beat always leaves idle
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted beat not started");
   // result count matches register
   a_rsp_cnt: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> rsp_ff.entry_count == 11'(count_ff)) else $error("count mismatch");
`endif

endmodule

### rtl/core/interval_heap_depq.sv
// interval heap double-ended priority queue, signed 32-bit keys
// Usage: raise start with req (opcode, key_in) while busy is low; the beat is
// taken at that edge and busy rises until the result is ready.
// Opcodes: insert, remove maximum, remove minimum, clear.
// Each beat gives one result beat on rsp, marked by rsp_strobe for one cycle;
// the receiver cannot stall, so it must take the result in that cycle.
// Clear, a rejected operation and an insert into an empty queue go straight
// to result collection; an insert climbs level by level, with a parent read
// and compare at each level, and a removal sinks level by level, with a
// partner read, two child reads and a move at each level. The cost is set by
// the single key store with registered read data and one read per cycle.
// busy drops in the strobe cycle, so the next beat can be taken at the same
// edge as the result; one item is in flight at a time.
// Reset: synchronous active-high reset empties the queue; the key store
// itself is not cleared; a value read from an empty slot is never used.
// Depends on ihdq_pkg, ihdq_ram, ihdq_seq.
module interval_heap_depq
   import ihdq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_beat,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_beat
);

   mem_req_type        mem_req;
   logic signed [31:0] rd_data;

   ihdq_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   ihdq_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_beat),
      .busy       (busy),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_beat)
   );

endmodule

### sim/tb.sv
// testbench for the interval heap double-ended priority queue
// drives opcode beats, predicts every result beat with a behavioral bag model
// depends on ihdq_pkg and interval_heap_depq
module tb;
   import ihdq_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_beat;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_beat;

   interval_heap_depq u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_beat   (req_beat),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_beat   (rsp_beat)
   );

   // predictor state: the held keys kept as a plain bag
   logic signed [31:0] held_keys[$];
   rsp_type            pending_rsp[$];
   int                 fail_count;
   int                 idle_cycles;
   int                 beats_sent;
   bit                 quiet_tail;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // index of the smallest or largest held key
   function automatic int extreme_index(input bit want_max);
      int best;
      best = 0;
      for (int i = 1; i < held_keys.size(); i++)
         if (want_max ? (held_keys[i] > held_keys[best]) : (held_keys[i] < held_keys[best]))
            best = i;
      return best;
   endfunction

   // apply one operation to the bag and form the expected result beat
   function automatic rsp_type heap_outcome(input req_type beat);
      rsp_type r;
      int      idx;
      r = '0;
      case (opcode_type'(beat.opcode))
         OP_INSERT: begin
            if (held_keys.size() >= Capacity) r.status = ST_FULL;
            else held_keys.push_back(beat.key_in);
         end
         OP_CLEAR: held_keys.delete();
         default: begin
            if (held_keys.size() == 0) r.status = ST_EMPTY;
            else begin
               idx = extreme_index(beat.opcode == OP_REM_MAX);
               r.removed_key   = held_keys[idx];
               r.removed_valid = 1'b1;
               held_keys.delete(idx);
            end
         end
      endcase
      if (held_keys.size() > 0) begin
         r.min_key = held_keys[extreme_index(1'b0)];
         r.max_key = held_keys[extreme_index(1'b1)];
      end
      r.entry_count = 11'(held_keys.size());
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $display("MISMATCH unexpected result beat at %0t", $realtime);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_beat.removed_key !== want.removed_key)
               report_mismatch("removed_key", rsp_beat.removed_key, want.removed_key);
            if (rsp_beat.removed_valid !== want.removed_valid)
               report_mismatch("removed_valid", rsp_beat.removed_valid, want.removed_valid);
            if (rsp_beat.min_key !== want.min_key)
               report_mismatch("min_key", rsp_beat.min_key, want.min_key);
            if (rsp_beat.max_key !== want.max_key)
               report_mismatch("max_key", rsp_beat.max_key, want.max_key);
            if (rsp_beat.entry_count !== want.entry_count)
               report_mismatch("entry_count", rsp_beat.entry_count, want.entry_count);
            if (rsp_beat.status !== want.status)
               report_mismatch("status", rsp_beat.status, want.status);
         end
      end
   end

   // watchdog on cycles with no accepted beat and no result
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // send one beat: hold start until taken, optional idle burst first
   task automatic send_beat(input opcode_type op, input logic signed [31:0] key,
                            input bit has_want, input rsp_type want);
      rsp_type pred;
      if (!quiet_tail && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 6)) @(posedge clock);
      start          <= 1'b1;
      req_beat.opcode <= op;
      req_beat.key_in <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      pred = heap_outcome('{opcode: op, key_in: key});
      if (has_want && pred !== want)
         $display("note: typed row differs from predictor at beat %0d", beats_sent);
      pending_rsp.push_back(has_want ? want : pred);
      beats_sent++;
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_key(input int spread);
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $urandom_range(0, spread) - spread / 2;
         default: return $urandom;
      endcase
   endfunction

   typedef struct {
      opcode_type         op;
      logic signed [31:0] key;
      bit                 has_want;
      rsp_type            want;
   } stim_row_type;

   stim_row_type directed_rows[$];

   function automatic rsp_type mk(input logic signed [31:0] rk, input logic rv,
                                  input logic signed [31:0] mn,
                                  input logic signed [31:0] mx,
                                  input int cnt, input status_type st);
      rsp_type r;
      r.removed_key = rk; r.removed_valid = rv; r.min_key = mn; r.max_key = mx;
      r.entry_count = 11'(cnt); r.status = st;
      return r;
   endfunction

   initial begin
      rsp_type            none;
      opcode_type         op;
      int                 pick;
      none        = '0;
      fail_count  = 0;
      idle_cycles = 0;
      beats_sent  = 0;
      quiet_tail  = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_beat    = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: empty removals, extremes, ties, clear
      directed_rows = '{
         '{OP_REM_MAX, 0, 1, mk(0, 0, 0, 0, 0, ST_EMPTY)},
         '{OP_REM_MIN, 0, 1, mk(0, 0, 0, 0, 0, ST_EMPTY)},
         '{OP_INSERT, 32'sh7fff_ffff, 1, mk(0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 1, ST_OK)},
         '{OP_INSERT, 32'sh8000_0000, 1,
           mk(0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 2, ST_OK)},
         '{OP_INSERT, 0, 0, none},
         '{OP_INSERT, -1, 0, none},
         '{OP_INSERT, -1, 0, none},
         '{OP_INSERT, 5, 0, none},
         '{OP_REM_MAX, 0, 0, none},
         '{OP_REM_MIN, 0, 0, none},
         '{OP_REM_MIN, 0, 0, none},
         '{OP_REM_MAX, 0, 0, none},
         '{OP_REM_MIN, 0, 0, none},
         '{OP_REM_MAX, 0, 0, none},
         '{OP_REM_MAX, 0, 1, mk(0, 0, 0, 0, 0, ST_EMPTY)},
         '{OP_INSERT, 42, 0, none},
         '{OP_INSERT, 42, 0, none},
         '{OP_CLEAR, 32'h5555_aaaa, 1, mk(0, 0, 0, 0, 0, ST_OK)},
         '{OP_REM_MIN, 0, 1, mk(0, 0, 0, 0, 0, ST_EMPTY)}
      };
      foreach (directed_rows[i])
         send_beat(directed_rows[i].op, directed_rows[i].key,
                   directed_rows[i].has_want, directed_rows[i].want);
      wait_drained();

      // fill to capacity with random keys, then hit the full case
      for (int i = 0; i < Capacity; i++)
         send_beat(OP_INSERT, rand_key(64), 0, none);
      send_beat(OP_INSERT, 32'sh7fff_ffff, 0, none);
      send_beat(OP_INSERT, 32'sh8000_0000, 0, none);
      // pause until every result is back
      wait_drained();
      // drain partially from both ends
      for (int i = 0; i < 60; i++)
         send_beat($urandom_range(0, 1) ? OP_REM_MAX : OP_REM_MIN, 0, 0, none);
      send_beat(OP_CLEAR, 0, 0, none);

      // random mix, small key spread for ties
      for (int i = 0; i < 150; i++) begin
         if (i > 100) quiet_tail = 1;
         pick = $urandom_range(0, 99);
         if (pick < 45) op = OP_INSERT;
         else if (pick < 70) op = OP_REM_MAX;
         else if (pick < 97) op = OP_REM_MIN;
         else op = OP_CLEAR;
         send_beat(op, rand_key($urandom_range(0, 1) ? 16 : 1000), 0, none);
      end

      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
